@@ rtl/afc_pkg.sv @@
package afc_pkg;

  localparam int unsigned MaxFrameBytes = 512;
  localparam int unsigned PosW          = 13;
  localparam int unsigned LenW          = 12;
  localparam int unsigned SumW          = 16;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [PosW-1:0] PosMax     = '1;
  localparam logic [PosW-1:0] PosLenLast = PosW'(12);
  localparam logic [PosW-1:0] PosInfo    = PosW'(13);
  localparam logic [PosW-1:0] LenFixed   = PosW'(18);

  localparam logic [7:0] StartCharRst  = 8'd126;
  localparam logic [7:0] EndCharRst    = 8'd13;
  localparam logic [7:0] VersionOneRst = 8'd32;
  localparam logic [7:0] VersionTwoRst = 8'd33;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartChar  = 2'd0,
    CfgEndChar    = 2'd1,
    CfgVersionOne = 2'd2,
    CfgVersionTwo = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ErrNone     = 4'd0,
    ErrStart    = 4'd1,
    ErrVersion  = 4'd2,
    ErrLenSum   = 4'd3,
    ErrChecksum = 4'd4,
    ErrEnd      = 4'd5,
    ErrShort    = 4'd6,
    ErrHex      = 4'd7,
    ErrLong     = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } word_t;

  typedef struct packed {
    logic            frame_ok;
    err_e            error_code;
    logic [LenW-1:0] info_length;
  } result_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] version_one;
    logic [7:0] version_two;
  } cfg_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic err_e note_err(input err_e cur, input logic cond, input err_e code);
    return (cur == ErrNone && cond) ? code : cur;
  endfunction

endpackage

@@ rtl/afc_in_stage.sv @@
module afc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  afc_pkg::word_t in_word_i,
  input  logic          out_busy_i,
  output logic          fire_o,
  output afc_pkg::word_t word_o
);

  logic           s_valid_q, s_valid_d;
  afc_pkg::word_t s_word_q;
  logic           accept;

  // a last word needs a free result register
  assign fire_o     = s_valid_q && !(s_word_q.last_byte && out_busy_i);
  assign in_stall_o = s_valid_q && !fire_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign word_o     = s_word_q;

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (fire_o) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_word_q <= in_word_i;
    end
  end

endmodule

@@ rtl/afc_frame_core.sv @@
module afc_frame_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  afc_pkg::word_t   word_i,
  input  afc_pkg::cfg_t    cfg_i,
  output afc_pkg::result_t result_o
);

  logic [afc_pkg::PosW-1:0] pos_q, pos_d;
  logic [afc_pkg::SumW-1:0] sum_q, sum_d;
  logic [3:0]               hold_q, hold_d;
  logic [7:0]               lh_q, lh_d;
  logic [7:0]               ll_q, ll_d;
  logic [afc_pkg::SumW-1:0] recv_q, recv_d;
  afc_pkg::err_e            err_q, err_d;
  logic                     end_q, end_d;

  afc_pkg::hex_t            hx;
  logic [7:0]               b;
  logic [7:0]               pair;
  logic [afc_pkg::PosW-1:0] cks;
  logic [afc_pkg::LenW-1:0] len_new;
  logic [3:0]               nsum;
  logic [3:0]               nchk;
  logic [afc_pkg::SumW-1:0] expect_sum;
  afc_pkg::err_e            code;

  always_comb begin
    b          = word_i.rx_byte;
    hx         = afc_pkg::hex_decode(b);
    pair       = {hold_q, hx.nib};
    cks        = afc_pkg::PosW'({lh_q[3:0], ll_q}) + afc_pkg::PosInfo;
    nsum       = lh_q[3:0] + pair[7:4] + pair[3:0];
    nchk       = 4'd0 - nsum;
    expect_sum = '0 - sum_q;

    pos_d  = (pos_q != afc_pkg::PosMax) ? pos_q + afc_pkg::PosW'(1) : pos_q;
    sum_d  = sum_q;
    hold_d = hold_q;
    lh_d   = lh_q;
    ll_d   = ll_q;
    recv_d = recv_q;
    err_d  = err_q;
    end_d  = end_q;

    if (pos_q == '0) begin
      err_d = afc_pkg::note_err(err_d, b != cfg_i.start_char, afc_pkg::ErrStart);
    end else if (pos_q <= afc_pkg::PosLenLast) begin
      sum_d = sum_q + afc_pkg::SumW'(b);
      if (pos_q == afc_pkg::PosW'(1) || pos_q == afc_pkg::PosW'(9)
          || pos_q == afc_pkg::PosW'(11)) begin
        hold_d = hx.nib;
        err_d  = afc_pkg::note_err(err_d, hx.bad, afc_pkg::ErrHex);
      end else if (pos_q == afc_pkg::PosW'(2)) begin
        err_d = afc_pkg::note_err(err_d, hx.bad, afc_pkg::ErrHex);
        err_d = afc_pkg::note_err(err_d,
                  pair != cfg_i.version_one && pair != cfg_i.version_two,
                  afc_pkg::ErrVersion);
      end else if (pos_q == afc_pkg::PosW'(10)) begin
        lh_d  = pair;
        err_d = afc_pkg::note_err(err_d, hx.bad, afc_pkg::ErrHex);
      end else if (pos_q == afc_pkg::PosLenLast) begin
        ll_d  = pair;
        err_d = afc_pkg::note_err(err_d, hx.bad, afc_pkg::ErrHex);
        err_d = afc_pkg::note_err(err_d, lh_q[7:4] != nchk, afc_pkg::ErrLenSum);
        err_d = afc_pkg::note_err(err_d,
                  afc_pkg::PosW'({lh_q[3:0], pair}) + afc_pkg::LenFixed
                  > afc_pkg::PosW'(afc_pkg::MaxFrameBytes),
                  afc_pkg::ErrLong);
      end
    end else if (pos_q < cks) begin
      sum_d = sum_q + afc_pkg::SumW'(b);
    end else if (pos_q < cks + afc_pkg::PosW'(4)) begin
      recv_d = {recv_q[afc_pkg::SumW-5:0], hx.nib};
      err_d  = afc_pkg::note_err(err_d, hx.bad, afc_pkg::ErrHex);
      if (pos_q == cks + afc_pkg::PosW'(3)) begin
        err_d = afc_pkg::note_err(err_d, expect_sum != recv_d, afc_pkg::ErrChecksum);
      end
    end else if (pos_q == cks + afc_pkg::PosW'(4)) begin
      err_d = afc_pkg::note_err(err_d, b != cfg_i.end_char, afc_pkg::ErrEnd);
      end_d = 1'b1;
    end

    len_new = {lh_d[3:0], ll_d};
    code    = (err_d == afc_pkg::ErrNone && !end_d) ? afc_pkg::ErrShort : err_d;
    result_o.frame_ok    = (code == afc_pkg::ErrNone);
    result_o.error_code  = code;
    result_o.info_length = (pos_d >= afc_pkg::PosInfo) ? len_new : '0;

    if (word_i.last_byte) begin
      pos_d  = '0;
      sum_d  = '0;
      hold_d = '0;
      lh_d   = '0;
      ll_d   = '0;
      recv_d = '0;
      err_d  = afc_pkg::ErrNone;
      end_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      hold_q <= '0;
      lh_q   <= '0;
      ll_q   <= '0;
      recv_q <= '0;
      err_q  <= afc_pkg::ErrNone;
      end_q  <= 1'b0;
    end else if (fire_i) begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      hold_q <= hold_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      recv_q <= recv_d;
      err_q  <= err_d;
      end_q  <= end_d;
    end
  end

endmodule

@@ rtl/afc_out_stage.sv @@
module afc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  afc_pkg::result_t result_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output afc_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  afc_pkg::result_t result_q;

  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

@@ rtl/ascii_hex_frame_checker_unit.sv @@
// A last word is registered in the input stage, and its verdict in the result register.
// Throughput: one word per cycle when not stalled; core frame state updates once per word.
// A new word is taken while a verdict waits; only a last word waits for the result register.
// Reset (async, active low) clears the frame state and restores the default characters
// and versions; no clearing pass, the block accepts words right after reset.
module ascii_hex_frame_checker_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         frame_ok_o,
  output logic [3:0]                   error_code_o,
  output logic [afc_pkg::LenW-1:0]     info_length_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [afc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  afc_pkg::cfg_t    cfg_q;
  afc_pkg::word_t   in_word;
  afc_pkg::word_t   core_word;
  afc_pkg::result_t core_result;
  afc_pkg::result_t out_result;
  logic             fire;
  logic             out_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char  <= afc_pkg::StartCharRst;
      cfg_q.end_char    <= afc_pkg::EndCharRst;
      cfg_q.version_one <= afc_pkg::VersionOneRst;
      cfg_q.version_two <= afc_pkg::VersionTwoRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (afc_pkg::cfg_idx_e'(cfg_index_i))
        afc_pkg::CfgStartChar:  cfg_q.start_char  <= cfg_data_i;
        afc_pkg::CfgEndChar:    cfg_q.end_char    <= cfg_data_i;
        afc_pkg::CfgVersionOne: cfg_q.version_one <= cfg_data_i;
        afc_pkg::CfgVersionTwo: cfg_q.version_two <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_word.rx_byte   = rx_byte_i;
  assign in_word.last_byte = last_byte_i;

  afc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word),
    .out_busy_i (out_busy),
    .fire_o     (fire),
    .word_o     (core_word)
  );

  afc_frame_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (core_word),
    .cfg_i    (cfg_q),
    .result_o (core_result)
  );

  afc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && core_word.last_byte),
    .result_i    (core_result),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign frame_ok_o    = out_result.frame_ok;
  assign error_code_o  = out_result.error_code;
  assign info_length_o = out_result.info_length;

endmodule

@@ rtl/afc_checker.sv @@
module afc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     frame_ok_o,
  input logic [3:0]               error_code_o,
  input logic [afc_pkg::LenW-1:0] info_length_o
);

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_ok_o == (error_code_o == afc_pkg::ErrNone)))
    else $error("frame_ok disagrees with error_code");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o <= afc_pkg::ErrLong))
    else $error("error_code out of range");

  a_ok_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_ok_o)
      |-> (32'(info_length_o) + 32'd18 <= 32'(afc_pkg::MaxFrameBytes)))
    else $error("passing frame longer than allowed");

  a_no_stall_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register is free");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(error_code_o) && $stable(info_length_o)))
    else $error("stalled result changed");

endmodule

bind ascii_hex_frame_checker_unit afc_checker u_afc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_ok_o    (frame_ok_o),
  .error_code_o  (error_code_o),
  .info_length_o (info_length_o)
);
